@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PAB_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("pixel blender check failed");

// next-cycle implication
`define PAB_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("pixel blender check failed");

`endif

@@ rtl/pab_pkg.sv @@
// ---------------------------------------------------------------------------
// pab_pkg
// Types and constants of the pixel alpha blender pipeline.
// ---------------------------------------------------------------------------
package pab_pkg;

	localparam int CH_W      = 8;
	localparam int NCOL      = 3;
	localparam int NCH       = 4;
	localparam int CFG_IDX_W = 3;
	localparam int WGT_W     = 16;
	localparam int MIX_W     = 17;
	localparam int NUM_W     = 25;
	localparam int QW        = 9;
	localparam int DIV_STEPS = QW;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILL_BLUE   = 3'd0,
		CFG_FILL_GREEN  = 3'd1,
		CFG_FILL_RED    = 3'd2,
		CFG_FILL_ALPHA  = 3'd3,
		CFG_FORCE_REPL  = 3'd4,
		CFG_TGT_ALPHA   = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_PASS       = 2'd0,
		MODE_REPL       = 2'd1,
		MODE_OVER_ALPHA = 2'd2,
		MODE_OVER_OPQ   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                              mode;
		logic [NCH-1:0][CH_W-1:0]           dst;
		logic [WGT_W-1:0]                   wd;
		logic [WGT_W-1:0]                   kk;
		logic [NCOL-1:0][MIX_W-1:0]         mix;
	} s1_t;

	typedef struct packed {
		logic                               use_div;
		logic [NCH-1:0][CH_W-1:0]           res;
		logic [WGT_W-1:0]                   den;
		logic [NCOL-1:0][NUM_W-1:0]         num;
	} s2_t;

	typedef struct packed {
		logic                               use_div;
		logic [NCH-1:0][CH_W-1:0]           res;
		logic [WGT_W-1:0]                   den;
		logic [NCOL-1:0][NUM_W-1:0]         rem;
		logic [NCOL-1:0][QW-1:0]            q;
	} div_t;

endpackage

@@ rtl/pixel_alpha_blender.sv @@
// ---------------------------------------------------------------------------
// pixel_alpha_blender
// Blends the fill color into a stream of BGRA pixels: pass, replace,
// source-over onto opaque or onto alpha targets.
// ---------------------------------------------------------------------------
// Pipeline: weights, products, then one restoring quotient bit per stage
//   over 9 stages.
// Throughput: one pixel per cycle; a stall on the output freezes the pipe.
// Reset: arst_n clears all valid bits and loads the fill registers with
//   color 0, alpha 255, no forced replace, opaque target.
`include "assert_macros.svh"

module pixel_alpha_blender (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pab_pkg::CH_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    dst_blue,
	input  logic [7:0]                    dst_green,
	input  logic [7:0]                    dst_red,
	input  logic [7:0]                    dst_alpha,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_alpha
);

	localparam int LAST = pab_pkg::DIV_STEPS - 1;

	logic [7:0] fill_blue_q, fill_green_q, fill_red_q, fill_alpha_q;
	logic       force_repl_q, tgt_alpha_q;

	logic       adv;
	logic       v_s1, v_s2;
	logic [pab_pkg::DIV_STEPS-1:0] vdiv_s3;
	pab_pkg::s1_t  pl_s1, nx_s1;
	pab_pkg::s2_t  pl_s2, nx_s2;
	pab_pkg::div_t div_s3 [pab_pkg::DIV_STEPS];
	pab_pkg::div_t last_s3;

	logic [pab_pkg::NCOL-1:0][7:0] fill_c;
	logic [7:0] k, kd;
	logic [8:0] a1;
	logic [pab_pkg::WGT_W-1:0] wf;
	logic       chk_rem;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_blue_q  <= 8'd0;
			fill_green_q <= 8'd0;
			fill_red_q   <= 8'd0;
			fill_alpha_q <= 8'd255;
			force_repl_q <= 1'b0;
			tgt_alpha_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pab_pkg::CFG_FILL_BLUE:  fill_blue_q  <= cfg_data;
				pab_pkg::CFG_FILL_GREEN: fill_green_q <= cfg_data;
				pab_pkg::CFG_FILL_RED:   fill_red_q   <= cfg_data;
				pab_pkg::CFG_FILL_ALPHA: fill_alpha_q <= cfg_data;
				pab_pkg::CFG_FORCE_REPL: force_repl_q <= cfg_data[0];
				pab_pkg::CFG_TGT_ALPHA:  tgt_alpha_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign fill_c = {fill_red_q, fill_green_q, fill_blue_q};
	assign k      = 8'd255 - fill_alpha_q;
	assign a1     = {1'b0, fill_alpha_q} + 9'd1;
	assign wf     = 16'(a1) * 16'd255;

	assign adv      = !vdiv_s3[LAST] || out_ready;
	assign in_ready = adv;

	// stage 1: mode decode and weight products
	assign kd = 8'd255 - dst_alpha;

	always_comb begin
		nx_s1.dst = {dst_alpha, dst_red, dst_green, dst_blue};
		if (fill_alpha_q == 8'd0 && !force_repl_q)
			nx_s1.mode = pab_pkg::MODE_PASS;
		else if (force_repl_q || fill_alpha_q == 8'd255)
			nx_s1.mode = pab_pkg::MODE_REPL;
		else if (tgt_alpha_q)
			nx_s1.mode = pab_pkg::MODE_OVER_ALPHA;
		else
			nx_s1.mode = pab_pkg::MODE_OVER_OPQ;
		nx_s1.wd = 16'({1'b0, dst_alpha} + 9'd1) * 16'(k);
		nx_s1.kk = 16'(kd) * 16'(k);
		for (int c = 0; c < pab_pkg::NCOL; c++) begin
			nx_s1.mix[c] = 17'(nx_s1.dst[c]) * 17'(k) + 17'(fill_c[c]) * 17'(a1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			pl_s1 <= nx_s1;
	end

	// stage 2: dividends, denominator, non-dividing results
	always_comb begin
		nx_s2.use_div = (pl_s1.mode == pab_pkg::MODE_OVER_ALPHA);
		nx_s2.den     = 16'hFFFF - pl_s1.kk;
		for (int c = 0; c < pab_pkg::NCOL; c++) begin
			nx_s2.num[c] = 25'(pl_s1.dst[c]) * 25'(pl_s1.wd) + 25'(fill_c[c]) * 25'(wf);
		end
		case (pl_s1.mode)
			pab_pkg::MODE_PASS: begin
				nx_s2.res = pl_s1.dst;
			end
			pab_pkg::MODE_REPL: begin
				nx_s2.res = {fill_alpha_q, fill_red_q, fill_green_q, fill_blue_q};
			end
			pab_pkg::MODE_OVER_ALPHA: begin
				nx_s2.res    = pl_s1.dst;
				nx_s2.res[3] = 8'd255 - pl_s1.kk[15:8];
			end
			default: begin
				nx_s2.res = pl_s1.dst;
				for (int c = 0; c < pab_pkg::NCOL; c++) begin
					nx_s2.res[c] = pl_s1.mix[c][16] ? 8'd255 : pl_s1.mix[c][15:8];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			pl_s2 <= nx_s2;
	end

	// stages 3..11: restoring divide, MSB first; quotient bit 8 flags saturation
	for (genvar j = 0; j < pab_pkg::DIV_STEPS; j++) begin : g_div
		pab_pkg::div_t src, nxt;
		logic          src_v;
		logic [pab_pkg::NUM_W-1:0] dsh;

		if (j == 0) begin : g_first
			assign src_v       = v_s2;
			assign src.use_div = pl_s2.use_div;
			assign src.res     = pl_s2.res;
			assign src.den     = pl_s2.den;
			assign src.rem     = pl_s2.num;
			assign src.q       = '0;
		end else begin : g_next
			assign src_v = vdiv_s3[j-1];
			assign src   = div_s3[j-1];
		end

		assign dsh = (pab_pkg::NUM_W)'(src.den) << (pab_pkg::QW - 1 - j);

		always_comb begin
			nxt = src;
			for (int c = 0; c < pab_pkg::NCOL; c++) begin
				if (src.rem[c] >= dsh) begin
					nxt.rem[c] = src.rem[c] - dsh;
					nxt.q[c][pab_pkg::QW-1-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vdiv_s3[j] <= 1'b0;
			else if (adv)
				vdiv_s3[j] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (adv)
				div_s3[j] <= nxt;
		end
	end

	// output
	assign last_s3   = div_s3[LAST];
	assign out_valid = vdiv_s3[LAST];
	assign out_alpha = last_s3.res[3];

	always_comb begin
		logic [pab_pkg::NCOL-1:0][7:0] col;
		for (int c = 0; c < pab_pkg::NCOL; c++) begin
			if (last_s3.use_div)
				col[c] = last_s3.q[c][pab_pkg::QW-1] ? 8'd255 : last_s3.q[c][7:0];
			else
				col[c] = last_s3.res[c];
		end
		out_blue  = col[0];
		out_green = col[1];
		out_red   = col[2];
	end

	assign chk_rem = out_valid && last_s3.use_div && !last_s3.q[0][pab_pkg::QW-1];

	`PAB_ASSERT_IMP(a_den_min, v_s2 && pl_s2.use_div, pl_s2.den >= 16'd765)
	`PAB_ASSERT_NEXT(a_valid_travel, adv && v_s2, vdiv_s3[0])
	`PAB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(last_s3))
	`PAB_ASSERT_IMP(a_rem_bound, chk_rem, last_s3.rem[0] < (pab_pkg::NUM_W)'(last_s3.den))

endmodule

@@ tb/sv/tb_pixel_alpha_blender.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pixel_alpha_blender
// Drives BGRA destination pixels through the blender under changing fill
// settings, predicts each blended pixel in the bench and compares every
// output beat field by field, with random idling and a long output stall.
// ---------------------------------------------------------------------------
module tb_pixel_alpha_blender;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
	} pix_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PIX,
		ROW_PIX_CHK
	} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [pab_pkg::CFG_IDX_W-1:0] idx;
		logic [7:0]                    val;
		pix_t                          px;
		pix_t                          want;
	} dir_row_t;

	localparam logic [pab_pkg::CFG_IDX_W-1:0] NO_IDX           = '0;
	localparam logic [pab_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_6 = 3'd6;
	localparam logic [pab_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_7 = 3'd7;
	localparam pix_t                          NO_PIX           = '0;
	localparam int                            DIR_N            = 42;
	localparam int                            HOLD_CYCLES      = 60;
	localparam int                            BLOCK_ITEMS      = 50;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'h12, 8'h34, 8'h56, 8'h78}, '{8'h00, 8'h00, 8'h00, 8'hff}},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, '{8'h00, 8'h00, 8'h00, 8'hff}},
		'{ROW_CFG, pab_pkg::CFG_FILL_BLUE,  8'hff, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_GREEN, 8'h00, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_RED,   8'h80, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'h00, NO_PIX, NO_PIX},
		// transparent fill: pixel passes through
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00}},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, '{8'hff, 8'hff, 8'hff, 8'hff}},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'ha5, 8'h5a, 8'h3c, 8'hc3}, '{8'ha5, 8'h5a, 8'h3c, 8'hc3}},
		// forced replace wins over a transparent fill
		'{ROW_CFG, pab_pkg::CFG_FORCE_REPL, 8'hff, NO_PIX, NO_PIX},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'h12, 8'h34, 8'h56, 8'h78}, '{8'hff, 8'h00, 8'h80, 8'h00}},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, '{8'hff, 8'h00, 8'h80, 8'h00}},
		'{ROW_CFG, pab_pkg::CFG_FORCE_REPL, 8'hfe, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'h01, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'h00, 8'h80, 8'h7f}, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'hfe, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_TGT_ALPHA, 8'h01, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h40, 8'hc0, 8'h01, 8'h80}, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'h01, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'h00}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'h80, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h7f, 8'h80, 8'hff, 8'h01}, NO_PIX},
		// unused indexes must not disturb the fill
		'{ROW_CFG, CFG_IDX_UNUSED_6, 8'hff, NO_PIX, NO_PIX},
		'{ROW_CFG, CFG_IDX_UNUSED_7, 8'hff, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'hff, NO_PIX, NO_PIX},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'h12, 8'h34, 8'h56, 8'h78}, '{8'hff, 8'h00, 8'h80, 8'hff}},
		'{ROW_CFG, pab_pkg::CFG_TGT_ALPHA,  8'h02, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_GREEN, 8'hff, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_RED,   8'h00, NO_PIX, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FILL_ALPHA, 8'h40, NO_PIX, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'h80, 8'h80, 8'h80, 8'h80}, NO_PIX},
		'{ROW_PIX, NO_IDX, 8'h00, '{8'hff, 8'hff, 8'hff, 8'hff}, NO_PIX},
		'{ROW_CFG, pab_pkg::CFG_FORCE_REPL, 8'h01, NO_PIX, NO_PIX},
		'{ROW_PIX_CHK, NO_IDX, 8'h00, '{8'h01, 8'h02, 8'h03, 8'h04}, '{8'hff, 8'hff, 8'h00, 8'h40}}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [pab_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pab_pkg::CH_W-1:0]      cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    dst_blue;
	logic [7:0]                    dst_green;
	logic [7:0]                    dst_red;
	logic [7:0]                    dst_alpha;
	logic                          out_valid;
	logic                          out_ready;
	logic [7:0]                    out_blue;
	logic [7:0]                    out_green;
	logic [7:0]                    out_red;
	logic [7:0]                    out_alpha;

	// bench copy of the fill registers
	bit [7:0] fc_blue;
	bit [7:0] fc_green;
	bit [7:0] fc_red;
	bit [7:0] fc_alpha;
	bit       fc_force;
	bit       fc_tgt_alpha;

	pix_t blend_q [$];
	int   err_cnt;
	int   snd_idle_pct;
	int   rcv_stall_pct;
	bit   hold_req;

	pixel_alpha_blender u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dst_blue  (dst_blue),
		.dst_green (dst_green),
		.dst_red   (dst_red),
		.dst_alpha (dst_alpha),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.out_alpha (out_alpha)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic bit [7:0] sat255(int unsigned v);
		return (v > 255) ? 8'hff : v[7:0];
	endfunction

	function automatic pix_t blend_pixel(pix_t d);
		int unsigned a;
		int unsigned da;
		int unsigned k;
		int unsigned kd;
		int unsigned wd;
		int unsigned wf;
		int unsigned den;
		int unsigned fc [3];
		int unsigned dc [3];
		bit [7:0]    ch [3];
		pix_t        res;
		a  = fc_alpha;
		da = d.a;
		fc = '{fc_blue, fc_green, fc_red};
		dc = '{d.b, d.g, d.r};
		if (a == 0 && !fc_force) begin
			res = d;
		end else if (fc_force || a == 255) begin
			res = '{fc_blue, fc_green, fc_red, fc_alpha};
		end else if (fc_tgt_alpha) begin
			k   = 255 - a;
			kd  = 255 - da;
			wd  = (da + 1) * k;
			wf  = (a + 1) * 255;
			den = 65535 - k * kd;
			for (int i = 0; i < 3; i++) begin
				ch[i] = sat255((dc[i] * wd + fc[i] * wf) / den);
			end
			res = '{ch[0], ch[1], ch[2], sat255(255 - ((kd * k) >> 8))};
		end else begin
			k  = 255 - a;
			wf = a + 1;
			for (int i = 0; i < 3; i++) begin
				ch[i] = sat255((dc[i] * k + fc[i] * wf) >> 8);
			end
			res = '{ch[0], ch[1], ch[2], d.a};
		end
		return res;
	endfunction

	function automatic bit [7:0] rand_chan();
		case ($urandom_range(6))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic cfg_write(input logic [pab_pkg::CFG_IDX_W-1:0] idx, input bit [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			pab_pkg::CFG_FILL_BLUE:  fc_blue      = val;
			pab_pkg::CFG_FILL_GREEN: fc_green     = val;
			pab_pkg::CFG_FILL_RED:   fc_red       = val;
			pab_pkg::CFG_FILL_ALPHA: fc_alpha     = val;
			pab_pkg::CFG_FORCE_REPL: fc_force     = val[0];
			pab_pkg::CFG_TGT_ALPHA:  fc_tgt_alpha = val[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid and wait until every pending pixel has left the pipe
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (blend_q.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic randomize_fill();
		bit [7:0] a;
		case ($urandom_range(9))
			0: a = 8'h00;
			1: a = 8'hff;
			2: a = 8'h01;
			3: a = 8'hfe;
			default: a = 8'($urandom_range(255));
		endcase
		cfg_write(pab_pkg::CFG_FILL_BLUE, rand_chan());
		cfg_write(pab_pkg::CFG_FILL_GREEN, rand_chan());
		cfg_write(pab_pkg::CFG_FILL_RED, rand_chan());
		cfg_write(pab_pkg::CFG_FILL_ALPHA, a);
		cfg_write(pab_pkg::CFG_FORCE_REPL,
			{7'($urandom_range(127)), 1'($urandom_range(3) == 0)});
		cfg_write(pab_pkg::CFG_TGT_ALPHA, {7'($urandom_range(127)), 1'($urandom_range(1))});
		if ($urandom_range(3) == 0)
			cfg_write($urandom_range(1) ? CFG_IDX_UNUSED_6 : CFG_IDX_UNUSED_7, rand_chan());
	endtask

	task automatic send_pixel(input pix_t px, input bit typed, input pix_t want);
		if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid  <= 1'b1;
		dst_blue  <= px.b;
		dst_green <= px.g;
		dst_red   <= px.r;
		dst_alpha <= px.a;
		do @(posedge clk); while (!in_ready);
		blend_q.push_back(typed ? want : blend_pixel(px));
	endtask

	task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_items,
			input bit squeeze);
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % BLOCK_ITEMS == 0) begin
				wait_drain();
				randomize_fill();
			end
			if (squeeze && i % BLOCK_ITEMS == 1)
				hold_req = 1'b1;
			send_pixel('{rand_chan(), rand_chan(), rand_chan(), rand_chan()}, 1'b0, NO_PIX);
		end
	endtask

	// receiver: random stalls, or a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	task automatic check_chan(input string nm, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %02h, got %02h", $time, nm, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : out_mon
		pix_t want;
		if (arst_n && out_valid && out_ready) begin
			if (blend_q.size() == 0) begin
				$display("%0t ns: output beat with nothing expected, got %02h %02h %02h %02h",
					$time, out_blue, out_green, out_red, out_alpha);
				err_cnt++;
			end else begin
				want = blend_q.pop_front();
				check_chan("blue", want.b, out_blue);
				check_chan("green", want.g, out_green);
				check_chan("red", want.r, out_red);
				check_chan("alpha", want.a, out_alpha);
			end
		end
	end

	initial begin
		err_cnt       = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req      = 1'b0;
		fc_blue       = 8'h00;
		fc_green      = 8'h00;
		fc_red        = 8'h00;
		fc_alpha      = 8'hff;
		fc_force      = 1'b0;
		fc_tgt_alpha  = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= NO_IDX;
		cfg_data  <= 8'h00;
		in_valid  <= 1'b0;
		dst_blue  <= 8'h00;
		dst_green <= 8'h00;
		dst_red   <= 8'h00;
		dst_alpha <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				wait_drain();
				cfg_write(DIR_TAB[i].idx, DIR_TAB[i].val);
			end else begin
				send_pixel(DIR_TAB[i].px, DIR_TAB[i].kind == ROW_PIX_CHK, DIR_TAB[i].want);
			end
		end

		run_phase(0, 0, 210, 1'b0);
		run_phase(82, 0, 200, 1'b0);
		run_phase(0, 82, 200, 1'b0);
		run_phase(25, 25, 210, 1'b0);
		run_phase(0, 0, 210, 1'b1);

		wait_drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
